[rtl/itda_pkg.sv]
// itda_pkg: constants and types for the decimal ASCII converter.
// No dependencies.
package itda_pkg;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdBits   = 4 * NumDigits;
  localparam int unsigned NumStages = 4;
  localparam int unsigned BitsPerStage = ValueBits / NumStages;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  typedef logic [BcdBits-1:0] bcd_t;
  typedef logic [ValueBits-1:0] mag_t;

  typedef struct packed {
    logic neg;
    mag_t mag;
    bcd_t bcd;
  } conv_t;

  // One double-dabble step: add 3 to each digit above 4, shift in a bit.
  function automatic bcd_t dabble(input bcd_t b, input logic bin);
    bcd_t t;
    t = b;
    for (int i = 0; i < NumDigits; i++) begin
      if (t[4*i +: 4] > 4'd4) t[4*i +: 4] = t[4*i +: 4] + 4'd3;
    end
    return {t[BcdBits-2:0], bin};
  endfunction
endpackage

[rtl/int_to_decimal_ascii_unit.sv]
// Converts a signed 32-bit integer to decimal ASCII characters.
// Depends on itda_pkg.
//
// An item passes a magnitude stage and then 4 double-dabble stages of 8 steps
// each, and is then loaded into the output serializer, which sends one
// character per cycle while out_tready is high (1 to 11 characters per item).
// The serializer sets the sustained rate; the pipeline accepts a new item each
// cycle while it has room.
module int_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] text_char
  output logic        out_tlast   // last
);
  import itda_pkg::*;

  conv_t   stg_r   [NumStages+1];
  logic    vld_r   [NumStages+1];
  logic    adv     [NumStages+1];

  // serializer state
  logic              busy_r;
  logic              neg_r;
  bcd_t              dig_r;
  logic [4:0]        cnt_r;   // characters left
  logic              sign_pend_r;
  logic [4:0]        nd;

  logic load;
  assign load = vld_r[NumStages] && (!busy_r ||
                (out_tready && cnt_r == 5'd1));

  // stall chain: a stage loads when it is empty or its item moves on
  always_comb begin
    adv[NumStages] = !vld_r[NumStages] || load;
    for (int s = NumStages - 1; s >= 0; s--) begin
      adv[s] = !vld_r[s] || adv[s+1];
    end
  end
  assign in_tready = adv[0];

  // entry stage: magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= NumStages; s++) vld_r[s] <= 1'b0;
    end else begin
      if (adv[0]) vld_r[0] <= in_tvalid;
      for (int s = 1; s <= NumStages; s++) begin
        if (adv[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_tvalid) begin
      stg_r[0].neg <= in_tdata[ValueBits-1];
      stg_r[0].mag <= in_tdata[ValueBits-1] ? mag_t'(-in_tdata) : in_tdata;
      stg_r[0].bcd <= '0;
    end
  end

  // dabble stages
  for (genvar g = 1; g <= NumStages; g++) begin : g_stage
    conv_t nxt;
    always_comb begin
      nxt = stg_r[g-1];
      for (int k = 0; k < BitsPerStage; k++) begin
        nxt.bcd = dabble(nxt.bcd, nxt.mag[ValueBits-1]);
        nxt.mag = {nxt.mag[ValueBits-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (adv[g] && vld_r[g-1]) stg_r[g] <= nxt;
    end
  end

  // digit count of the final BCD value
  always_comb begin
    nd = 5'd1;
    for (int i = 1; i < NumDigits; i++) begin
      if (stg_r[NumStages].bcd[4*i +: 4] != 4'd0) nd = 5'(i + 1);
    end
  end

  // output serializer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      sign_pend_r <= 1'b0;
    end else if (load) begin
      busy_r      <= 1'b1;
      sign_pend_r <= stg_r[NumStages].neg;
      cnt_r       <= nd + 5'(stg_r[NumStages].neg);
    end else if (busy_r && out_tready) begin
      cnt_r <= cnt_r - 5'd1;
      if (sign_pend_r) sign_pend_r <= 1'b0;
      if (cnt_r == 5'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dig_r <= stg_r[NumStages].bcd;
      neg_r <= stg_r[NumStages].neg;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tlast  = (cnt_r == 5'd1);
  always_comb begin
    out_tdata = CharMinus;
    if (!sign_pend_r) begin
      out_tdata = CharZero;
      for (int i = 0; i < NumDigits; i++) begin
        if (5'(i + 1) == cnt_r) out_tdata = CharZero + {4'd0, dig_r[4*i +: 4]};
      end
    end
  end

  // checks
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 5'd0) else $error("busy with no characters left");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'd11) else $error("character count too large");
  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && sign_pend_r) |-> neg_r) else $error("sign on positive value");
endmodule
